### rtl/core/nine_bit_frame_builder_fletcher_macros.svh
// Assertion macros for the nine-bit frame builder.
// Relies on signals named clk and rst_n in the module that uses them.
`ifndef NINE_BIT_FRAME_BUILDER_FLETCHER_MACROS_SVH
`define NINE_BIT_FRAME_BUILDER_FLETCHER_MACROS_SVH

// Expression must hold at every clock edge out of reset.
`define NBFB_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NBFB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/nbfb_pkg.sv
// Package for the nine-bit frame builder: beat types and fixed constants.
// No dependencies.
package nbfb_pkg;

    localparam logic [8:0] ADDR_MARK = 9'h100;
    localparam logic [8:0] FL_MOD    = 9'd255;

    // Tail words still queued behind the word on the output.
    localparam logic [1:0] TAIL_NONE = 2'd0;
    localparam logic [1:0] TAIL_HIGH = 2'd1;
    localparam logic [1:0] TAIL_BOTH = 2'd2;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       frame_end;
    } in_item_t;

    typedef struct packed {
        logic [8:0] bus_word;
        logic       run_last;
    } out_item_t;

endpackage

### rtl/core/nine_bit_frame_builder_fletcher.sv
// Top level of the nine-bit frame builder with Fletcher-16 checksum.
// Depends on nbfb_pkg and nine_bit_frame_builder_fletcher_macros.svh.
//
// Takes one payload byte per beat and sends it as a 9-bit bus word, with bit 8 set on
// the first byte of a frame. On the byte flagged frame_end it appends the low and then
// the high Fletcher-16 sum (mod 255). run_last marks the high sum and every data byte
// but the frame_end byte. Throughput is one byte per cycle while result_stall is low;
// the output register holds the last byte of a frame and then both sums, and no new
// byte reaches the output until the sums are gone. A beat goes from an input register
// through the single pass that updates the running sums into the output register, and
// the input register can take one beat while the output waits.
module nine_bit_frame_builder_fletcher (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  nbfb_pkg::in_item_t item,
    output logic               result_valid,
    input  logic               result_stall,
    output nbfb_pkg::out_item_t result
);

    logic                in_valid_reg, in_valid_next;
    nbfb_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg, out_valid_next;
    nbfb_pkg::out_item_t out_item_reg, out_item_next;
    logic [1:0]          tail_cnt_reg, tail_cnt_next;
    logic [7:0]          cks_lo_reg, cks_lo_next;
    logic [7:0]          cks_hi_reg, cks_hi_next;
    logic [7:0]          sum_low_reg, sum_low_next;
    logic [7:0]          sum_high_reg, sum_high_next;
    logic                at_start_reg, at_start_next;

    logic       in_take;
    logic       out_pop;
    logic       out_free;
    logic       move;
    logic [8:0] low_add;
    logic [8:0] high_add;
    logic [7:0] low_mod;
    logic [7:0] high_mod;

    assign out_pop  = out_valid_reg && !result_stall;
    assign out_free = !out_valid_reg || (out_pop && tail_cnt_reg == nbfb_pkg::TAIL_NONE);
    assign move     = in_valid_reg && out_free;

    assign item_stall = in_valid_reg && !move;
    assign in_take    = item_valid && !item_stall;

    // Fletcher sums, reduced with one conditional subtract each.
    always_comb
    begin
        low_add  = {1'b0, sum_low_reg} + {1'b0, in_item_reg.payload_byte};
        low_mod  = (low_add >= nbfb_pkg::FL_MOD) ? 8'(low_add - nbfb_pkg::FL_MOD)
                                                 : low_add[7:0];
        high_add = {1'b0, sum_high_reg} + {1'b0, low_mod};
        high_mod = (high_add >= nbfb_pkg::FL_MOD) ? 8'(high_add - nbfb_pkg::FL_MOD)
                                                  : high_add[7:0];
    end

    always_comb
    begin
        in_valid_next  = in_take ? 1'b1 : (move ? 1'b0 : in_valid_reg);
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        tail_cnt_next  = tail_cnt_reg;
        cks_lo_next    = cks_lo_reg;
        cks_hi_next    = cks_hi_reg;
        sum_low_next   = sum_low_reg;
        sum_high_next  = sum_high_reg;
        at_start_next  = at_start_reg;

        if (move)
        begin
            out_valid_next         = 1'b1;
            out_item_next.bus_word = {1'b0, in_item_reg.payload_byte}
                                     | (at_start_reg ? nbfb_pkg::ADDR_MARK : 9'd0);
            out_item_next.run_last = !in_item_reg.frame_end;
            if (in_item_reg.frame_end)
            begin
                tail_cnt_next = nbfb_pkg::TAIL_BOTH;
                cks_lo_next   = low_mod;
                cks_hi_next   = high_mod;
                sum_low_next  = 8'd0;
                sum_high_next = 8'd0;
                at_start_next = 1'b1;
            end
            else
            begin
                tail_cnt_next = nbfb_pkg::TAIL_NONE;
                sum_low_next  = low_mod;
                sum_high_next = high_mod;
                at_start_next = 1'b0;
            end
        end
        else if (out_pop)
        begin
            // Advance through the checksum words, else drop the beat.
            case (tail_cnt_reg)
                nbfb_pkg::TAIL_BOTH:
                begin
                    out_item_next.bus_word = {1'b0, cks_lo_reg};
                    out_item_next.run_last = 1'b0;
                    tail_cnt_next          = nbfb_pkg::TAIL_HIGH;
                end
                nbfb_pkg::TAIL_HIGH:
                begin
                    out_item_next.bus_word = {1'b0, cks_hi_reg};
                    out_item_next.run_last = 1'b1;
                    tail_cnt_next          = nbfb_pkg::TAIL_NONE;
                end
                default:
                begin
                    out_valid_next = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            tail_cnt_reg  <= nbfb_pkg::TAIL_NONE;
            sum_low_reg   <= 8'd0;
            sum_high_reg  <= 8'd0;
            at_start_reg  <= 1'b1;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            tail_cnt_reg  <= tail_cnt_next;
            sum_low_reg   <= sum_low_next;
            sum_high_reg  <= sum_high_next;
            at_start_reg  <= at_start_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_item_reg <= item;
        end
        out_item_reg <= out_item_next;
        cks_lo_reg   <= cks_lo_next;
        cks_hi_reg   <= cks_hi_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_item_reg;

`include "nine_bit_frame_builder_fletcher_macros.svh"

    `NBFB_ASSERT_ALWAYS(a_tail_needs_valid,
        (tail_cnt_reg == nbfb_pkg::TAIL_NONE) || out_valid_reg,
        "checksum words queued without a valid beat")
    `NBFB_ASSERT_ALWAYS(a_sums_reduced,
        (sum_low_reg != 8'hFF) && (sum_high_reg != 8'hFF),
        "running sum left unreduced")
    `NBFB_ASSERT_NEXT(a_end_queues_tail,
        move && in_item_reg.frame_end,
        tail_cnt_reg == nbfb_pkg::TAIL_BOTH && at_start_reg,
        "frame end did not queue both checksum words")

endmodule
